/* rtl/core/nsdf_pkg.sv */
// shared types, opcodes and constants of the duration to fraction block
`timescale 1ns / 1ps
`default_nettype none
package nsdf_pkg;

   localparam logic [31:0] NS_PER_SEC = 32'd1000000000;
   localparam logic [3:0]  EXP_MAX    = 4'd9;
   localparam logic [31:0] LIM_RESET  = 32'd65535;
   localparam logic [2:0]  FIVE       = 3'd5;
   // ceil(2^21 / 5), exact quotient for dividends below 5 * 2^16
   localparam logic [18:0] RECIP5     = 19'd419431;

   typedef enum logic [5:0] {
      OP_NOP,
      OP_LOAD,
      OP_THR,
      OP_RES_INF,
      OP_HALVE,
      OP_DIV5,
      OP_TAKE5,
      OP_RES_EXACT,
      OP_DIVQ,
      OP_RES_BIG,
      OP_INIT,
      OP_RES_CUR,
      OP_DIVC,
      OP_COEF,
      OP_CN,
      OP_CD,
      OP_ADV,
      OP_DIVK1,
      OP_KF1,
      OP_DIVK2,
      OP_KF2,
      OP_SEMI,
      OP_HALF,
      OP_RES_CAND,
      OP_E1,
      OP_E2,
      OP_E3,
      OP_E4,
      OP_E5,
      OP_E6,
      OP_E7,
      OP_E8,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   sel_new;
   } cmd_type;

   typedef struct packed {
      logic too_big;
      logic halve_ok;
      logic b_zero;
      logic div_done;
      logic five_done;
      logic five_rem_zero;
      logic fits;
      logic quot_big;
      logic rm_zero;
      logic cand_over;
      logic kf_gt_half;
      logic k2_zero;
      logic pn_zero;
      logic new_wins;
   } stat_type;

   function automatic logic [29:0] pow5(input logic [3:0] e);
      logic [29:0] v;
      case (e)
         4'd0: v = 30'd1;
         4'd1: v = 30'd5;
         4'd2: v = 30'd25;
         4'd3: v = 30'd125;
         4'd4: v = 30'd625;
         4'd5: v = 30'd3125;
         4'd6: v = 30'd15625;
         4'd7: v = 30'd78125;
         4'd8: v = 30'd390625;
         4'd9: v = 30'd1953125;
         default: v = 30'd1;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/nsdf_div.sv */
// radix-2 restoring divider, 64 or 32 quotient bits, one bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module nsdf_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        wide,
   input  wire logic [63:0] dividend,
   input  wire logic [31:0] divisor,
   output logic      [63:0] quotient,
   output logic      [31:0] remainder,
   output logic             done
);

   localparam logic [6:0] STEPS_WIDE   = 7'd64;
   localparam logic [6:0] STEPS_NARROW = 7'd32;

   logic [63:0] q_ff, q_in;
   logic [31:0] r_ff, r_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] shifted, diff;
   logic        ge;

   assign shifted = {r_ff, q_ff[63]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign ge      = shifted >= {1'b0, dsr_ff};

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = wide ? dividend : {dividend[31:0], 32'd0};
         r_in    = 32'd0;
         dsr_in  = divisor;
         cnt_in  = wide ? STEPS_WIDE : STEPS_NARROW;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in   = {q_ff[62:0], ge};
         r_in   = ge ? diff[31:0] : shifted[31:0];
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      r_ff   <= r_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         cnt_ff  <= 7'd0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = q_ff;
   assign remainder = r_ff;
   assign done      = done_ff;

endmodule
`default_nettype wire

/* rtl/core/nsdf_dp.sv */
// datapath: term registers, shared multiplier, divider and error accumulators
`timescale 1ns / 1ps
`default_nettype none
module nsdf_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire nsdf_pkg::cmd_type cmd,
   input  wire logic [63:0]       req_duration_ns,
   input  wire logic              csr_wr_en,
   input  wire logic [31:0]       csr_wr_data,
   output nsdf_pkg::stat_type     stat,
   output logic      [31:0]       rsp_frac_num,
   output logic      [31:0]       rsp_frac_den
);

   localparam logic [2:0] F5_STEPS = 3'd4;

   logic [31:0] lim_ff;
   logic [63:0] d_ff, d_in;
   logic [3:0]  a_ff, a_in, b_ff, b_in;
   logic [31:0] pn_ff, pn_in, qn_ff, qn_in, pp_ff, pp_in, qp_ff, qp_in;
   logic [31:0] dv_ff, dv_in, rm_ff, rm_in;
   logic [31:0] coef_ff, coef_in, kk_ff, kk_in, kf_ff, kf_in;
   logic [63:0] cn_ff, cn_in, cd_ff, cd_in;
   logic [63:0] prod_ff, t_ff, t_in;
   logic [95:0] eacc_ff, eacc_in, eo_ff, eo_in, en_ff, en_in;
   logic [31:0] res_num_ff, res_num_in, res_den_ff, res_den_in;
   logic [31:0] out_num_ff, out_num_in, out_den_ff, out_den_in;

   logic [31:0] qx, mul_a, mul_b, p_sel, q_sel, m_sel;
   logic [63:0] mul_p, lim64;

   logic        div_start, div_wide, div_done;
   logic [63:0] div_dividend, div_quot;
   logic [31:0] div_divisor, div_rem;

   logic [63:0] f5_q_ff, f5_q_in;
   logic [2:0]  f5_r_ff, f5_r_in;
   logic [2:0]  f5_cnt_ff, f5_cnt_in;
   logic        f5_busy_ff, f5_busy_in, f5_done_ff, f5_done_in;
   logic [18:0] f5_v, f5_q5, f5_rd;
   logic [37:0] f5_prod;
   logic [15:0] f5_qd;

   assign qx    = {2'b00, nsdf_pkg::pow5(b_ff)} << a_ff;
   assign lim64 = {32'd0, lim_ff};
   assign p_sel = cmd.sel_new ? cn_ff[31:0] : pn_ff;
   assign q_sel = cmd.sel_new ? cd_ff[31:0] : qn_ff;
   assign m_sel = cmd.sel_new ? qn_ff : cd_ff[31:0];
   assign mul_p = mul_a * mul_b;

   nsdf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .wide      (div_wide),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quot),
      .remainder (div_rem),
      .done      (div_done)
   );

   // divide by five, sixteen dividend bits per cycle by reciprocal multiply
   assign f5_v    = {f5_r_ff, f5_q_ff[63:48]};
   assign f5_prod = {19'd0, f5_v} * {19'd0, nsdf_pkg::RECIP5};
   assign f5_qd   = f5_prod[36:21];
   assign f5_q5   = {3'd0, f5_qd} * {16'd0, nsdf_pkg::FIVE};
   assign f5_rd   = f5_v - f5_q5;

   always_comb begin
      f5_q_in    = f5_q_ff;
      f5_r_in    = f5_r_ff;
      f5_cnt_in  = f5_cnt_ff;
      f5_busy_in = f5_busy_ff;
      f5_done_in = 1'b0;
      if (cmd.op == nsdf_pkg::OP_DIV5) begin
         f5_q_in    = d_ff;
         f5_r_in    = 3'd0;
         f5_cnt_in  = F5_STEPS;
         f5_busy_in = 1'b1;
      end else if (f5_busy_ff) begin
         f5_q_in   = {f5_q_ff[47:0], f5_qd};
         f5_r_in   = f5_rd[2:0];
         f5_cnt_in = f5_cnt_ff - 3'd1;
         if (f5_cnt_ff == 3'd1) begin
            f5_busy_in = 1'b0;
            f5_done_in = 1'b1;
         end
      end
   end

   // multiplier operands and divider launch
   always_comb begin
      mul_a        = 32'd0;
      mul_b        = 32'd0;
      div_start    = 1'b0;
      div_wide     = 1'b0;
      div_dividend = 64'd0;
      div_divisor  = 32'd1;
      case (cmd.op)
         nsdf_pkg::OP_THR: begin
            mul_a = lim_ff;
            mul_b = nsdf_pkg::NS_PER_SEC;
         end
         nsdf_pkg::OP_COEF: begin
            mul_a = pn_ff;
            mul_b = div_quot[31:0];
         end
         nsdf_pkg::OP_CN: begin
            mul_a = qn_ff;
            mul_b = kk_ff;
         end
         nsdf_pkg::OP_SEMI: begin
            mul_a = pn_ff;
            mul_b = kf_ff;
         end
         nsdf_pkg::OP_HALF: begin
            mul_a = pn_ff;
            mul_b = {1'b0, coef_ff[31:1]};
         end
         nsdf_pkg::OP_E1: begin
            mul_a = p_sel;
            mul_b = qx;
         end
         nsdf_pkg::OP_E2: begin
            mul_a = d_ff[31:0];
            mul_b = q_sel;
         end
         nsdf_pkg::OP_E3: begin
            mul_a = d_ff[63:32];
            mul_b = q_sel;
         end
         nsdf_pkg::OP_E6: begin
            mul_a = t_ff[31:0];
            mul_b = m_sel;
         end
         nsdf_pkg::OP_E7: begin
            mul_a = t_ff[63:32];
            mul_b = m_sel;
         end
         nsdf_pkg::OP_DIVQ: begin
            div_start    = 1'b1;
            div_wide     = 1'b1;
            div_dividend = d_ff;
            div_divisor  = qx;
         end
         nsdf_pkg::OP_DIVC: begin
            div_start    = 1'b1;
            div_dividend = {32'd0, dv_ff};
            div_divisor  = rm_ff;
         end
         nsdf_pkg::OP_DIVK1: begin
            div_start    = 1'b1;
            div_dividend = {32'd0, lim_ff - qp_ff};
            div_divisor  = qn_ff;
         end
         nsdf_pkg::OP_DIVK2: begin
            div_start    = 1'b1;
            div_dividend = {32'd0, lim_ff - pp_ff};
            div_divisor  = pn_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      d_in       = d_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      pn_in      = pn_ff;
      qn_in      = qn_ff;
      pp_in      = pp_ff;
      qp_in      = qp_ff;
      dv_in      = dv_ff;
      rm_in      = rm_ff;
      coef_in    = coef_ff;
      kk_in      = kk_ff;
      kf_in      = kf_ff;
      cn_in      = cn_ff;
      cd_in      = cd_ff;
      t_in       = t_ff;
      eacc_in    = eacc_ff;
      eo_in      = eo_ff;
      en_in      = en_ff;
      res_num_in = res_num_ff;
      res_den_in = res_den_ff;
      out_num_in = out_num_ff;
      out_den_in = out_den_ff;
      case (cmd.op)
         nsdf_pkg::OP_LOAD: begin
            d_in = req_duration_ns;
            a_in = nsdf_pkg::EXP_MAX;
            b_in = nsdf_pkg::EXP_MAX;
         end
         nsdf_pkg::OP_RES_INF: begin
            res_num_in = 32'd1;
            res_den_in = 32'd0;
         end
         nsdf_pkg::OP_HALVE: begin
            d_in = {1'b0, d_ff[63:1]};
            a_in = a_ff - 4'd1;
         end
         nsdf_pkg::OP_TAKE5: begin
            d_in = f5_q_ff;
            b_in = b_ff - 4'd1;
         end
         nsdf_pkg::OP_RES_EXACT: begin
            res_num_in = d_ff[31:0];
            res_den_in = qx;
         end
         nsdf_pkg::OP_RES_BIG: begin
            res_num_in = div_quot[31:0];
            res_den_in = 32'd1;
         end
         nsdf_pkg::OP_INIT: begin
            pn_in = div_quot[31:0];
            qn_in = 32'd1;
            pp_in = 32'd1;
            qp_in = 32'd0;
            dv_in = qx;
            rm_in = div_rem;
         end
         nsdf_pkg::OP_RES_CUR: begin
            res_num_in = pn_ff;
            res_den_in = qn_ff;
         end
         nsdf_pkg::OP_COEF: begin
            coef_in = div_quot[31:0];
            kk_in   = div_quot[31:0];
            dv_in   = rm_ff;
            rm_in   = div_rem;
         end
         nsdf_pkg::OP_CN: cn_in = prod_ff + {32'd0, pp_ff};
         nsdf_pkg::OP_CD: cd_in = prod_ff + {32'd0, qp_ff};
         nsdf_pkg::OP_ADV: begin
            pp_in = pn_ff;
            pn_in = cn_ff[31:0];
            qp_in = qn_ff;
            qn_in = cd_ff[31:0];
         end
         nsdf_pkg::OP_KF1: kf_in = div_quot[31:0];
         nsdf_pkg::OP_KF2: begin
            if (div_quot[31:0] < kf_ff) begin
               kf_in = div_quot[31:0];
            end
         end
         nsdf_pkg::OP_SEMI: kk_in = kf_ff;
         nsdf_pkg::OP_HALF: kk_in = {1'b0, coef_ff[31:1]};
         nsdf_pkg::OP_RES_CAND: begin
            res_num_in = cn_ff[31:0];
            res_den_in = cd_ff[31:0];
         end
         nsdf_pkg::OP_E2: t_in = prod_ff;
         nsdf_pkg::OP_E3: t_in = t_ff - prod_ff;
         nsdf_pkg::OP_E4: t_in = t_ff - {prod_ff[31:0], 32'd0};
         nsdf_pkg::OP_E5: t_in = t_ff[63] ? (64'd0 - t_ff) : t_ff;
         nsdf_pkg::OP_E7: eacc_in = {32'd0, prod_ff};
         nsdf_pkg::OP_E8: begin
            if (cmd.sel_new) begin
               en_in = eacc_ff + {prod_ff, 32'd0};
            end else begin
               eo_in = eacc_ff + {prod_ff, 32'd0};
            end
         end
         nsdf_pkg::OP_OUT: begin
            out_num_in = res_num_ff;
            out_den_in = res_den_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= nsdf_pkg::LIM_RESET;
      end else if (csr_wr_en) begin
         lim_ff <= csr_wr_data;
      end
      d_ff       <= d_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      pn_ff      <= pn_in;
      qn_ff      <= qn_in;
      pp_ff      <= pp_in;
      qp_ff      <= qp_in;
      dv_ff      <= dv_in;
      rm_ff      <= rm_in;
      coef_ff    <= coef_in;
      kk_ff      <= kk_in;
      kf_ff      <= kf_in;
      cn_ff      <= cn_in;
      cd_ff      <= cd_in;
      prod_ff    <= mul_p;
      t_ff       <= t_in;
      eacc_ff    <= eacc_in;
      eo_ff      <= eo_in;
      en_ff      <= en_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      out_num_ff <= out_num_in;
      out_den_ff <= out_den_in;
   end

   always_ff @(posedge clock) begin
      f5_q_ff   <= f5_q_in;
      f5_r_ff   <= f5_r_in;
      f5_cnt_ff <= f5_cnt_in;
      if (reset) begin
         f5_busy_ff <= 1'b0;
         f5_done_ff <= 1'b0;
      end else begin
         f5_busy_ff <= f5_busy_in;
         f5_done_ff <= f5_done_in;
      end
   end

   always_comb begin
      stat.too_big       = (lim_ff == 32'd0) ||
                           (d_ff >= prod_ff + {32'd0, nsdf_pkg::NS_PER_SEC});
      stat.halve_ok      = (a_ff != 4'd0) && !d_ff[0];
      stat.b_zero        = (b_ff == 4'd0);
      stat.div_done      = div_done;
      stat.five_done     = f5_done_ff;
      stat.five_rem_zero = (f5_r_ff == 3'd0);
      stat.fits          = (d_ff <= lim64) && (qx <= lim_ff);
      stat.quot_big      = (div_quot > lim64);
      stat.rm_zero       = (rm_ff == 32'd0);
      stat.cand_over     = (cn_ff > lim64) || (cd_ff > lim64);
      stat.kf_gt_half    = (kf_ff > {1'b0, coef_ff[31:1]});
      stat.k2_zero       = (coef_ff[31:1] == 31'd0);
      stat.pn_zero       = (pn_ff == 32'd0);
      stat.new_wins      = (en_ff <= eo_ff);
   end

   assign rsp_frac_num = out_num_ff;
   assign rsp_frac_den = out_den_ff;

endmodule
`default_nettype wire

/* rtl/core/nsdf_ctrl.sv */
// controller: sequences reduction, euclid steps, semiconvergent choice and handshakes
`timescale 1ns / 1ps
`default_nettype none
module nsdf_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire nsdf_pkg::stat_type stat,
   output nsdf_pkg::cmd_type       cmd
);

   typedef enum logic [22:0] {
      S_IDLE   = 23'h000001,
      S_THR    = 23'h000002,
      S_CHK    = 23'h000004,
      S_TWO    = 23'h000008,
      S_FIVE   = 23'h000010,
      S_FIVE_W = 23'h000020,
      S_FIT    = 23'h000040,
      S_INIT_W = 23'h000080,
      S_LOOP   = 23'h000100,
      S_COEF_W = 23'h000200,
      S_CN     = 23'h000400,
      S_CD     = 23'h000800,
      S_TEST   = 23'h001000,
      S_K1_W   = 23'h002000,
      S_K2     = 23'h004000,
      S_K2_W   = 23'h008000,
      S_PICK   = 23'h010000,
      S_KN     = 23'h020000,
      S_KD     = 23'h040000,
      S_KEND   = 23'h080000,
      S_ERR    = 23'h100000,
      S_CMP    = 23'h200000,
      S_OUT    = 23'h400000
   } state_type;

   state_type   state_ff, state_in;
   logic        semi_ff, semi_in;
   logic        sel_ff, sel_in;
   logic [2:0]  step_ff, step_in;
   logic        rsp_valid_ff, rsp_valid_in;
   nsdf_pkg::op_type err_op;

   always_comb begin
      case (step_ff)
         3'd0:    err_op = nsdf_pkg::OP_E1;
         3'd1:    err_op = nsdf_pkg::OP_E2;
         3'd2:    err_op = nsdf_pkg::OP_E3;
         3'd3:    err_op = nsdf_pkg::OP_E4;
         3'd4:    err_op = nsdf_pkg::OP_E5;
         3'd5:    err_op = nsdf_pkg::OP_E6;
         3'd6:    err_op = nsdf_pkg::OP_E7;
         default: err_op = nsdf_pkg::OP_E8;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      semi_in     = semi_ff;
      sel_in      = sel_ff;
      step_in     = step_ff;
      cmd.op      = nsdf_pkg::OP_NOP;
      cmd.sel_new = sel_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = nsdf_pkg::OP_LOAD;
               state_in = S_THR;
            end
         end
         S_THR: begin
            cmd.op   = nsdf_pkg::OP_THR;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (stat.too_big) begin
               cmd.op   = nsdf_pkg::OP_RES_INF;
               state_in = S_OUT;
            end else begin
               state_in = S_TWO;
            end
         end
         S_TWO: begin
            if (stat.halve_ok) begin
               cmd.op = nsdf_pkg::OP_HALVE;
            end else begin
               state_in = S_FIVE;
            end
         end
         S_FIVE: begin
            if (stat.b_zero) begin
               state_in = S_FIT;
            end else begin
               cmd.op   = nsdf_pkg::OP_DIV5;
               state_in = S_FIVE_W;
            end
         end
         S_FIVE_W: begin
            if (stat.five_done) begin
               if (stat.five_rem_zero) begin
                  cmd.op   = nsdf_pkg::OP_TAKE5;
                  state_in = S_FIVE;
               end else begin
                  state_in = S_FIT;
               end
            end
         end
         S_FIT: begin
            if (stat.fits) begin
               cmd.op   = nsdf_pkg::OP_RES_EXACT;
               state_in = S_OUT;
            end else begin
               cmd.op   = nsdf_pkg::OP_DIVQ;
               state_in = S_INIT_W;
            end
         end
         S_INIT_W: begin
            if (stat.div_done) begin
               if (stat.quot_big) begin
                  cmd.op   = nsdf_pkg::OP_RES_BIG;
                  state_in = S_OUT;
               end else begin
                  cmd.op   = nsdf_pkg::OP_INIT;
                  state_in = S_LOOP;
               end
            end
         end
         S_LOOP: begin
            if (stat.rm_zero) begin
               cmd.op   = nsdf_pkg::OP_RES_CUR;
               state_in = S_OUT;
            end else begin
               cmd.op   = nsdf_pkg::OP_DIVC;
               state_in = S_COEF_W;
            end
         end
         S_COEF_W: begin
            if (stat.div_done) begin
               cmd.op   = nsdf_pkg::OP_COEF;
               state_in = S_CN;
            end
         end
         S_CN: begin
            cmd.op   = nsdf_pkg::OP_CN;
            state_in = S_CD;
         end
         S_CD: begin
            cmd.op   = nsdf_pkg::OP_CD;
            state_in = S_TEST;
         end
         S_TEST: begin
            if (stat.cand_over) begin
               cmd.op   = nsdf_pkg::OP_DIVK1;
               state_in = S_K1_W;
            end else begin
               cmd.op   = nsdf_pkg::OP_ADV;
               state_in = S_LOOP;
            end
         end
         S_K1_W: begin
            if (stat.div_done) begin
               cmd.op   = nsdf_pkg::OP_KF1;
               state_in = S_K2;
            end
         end
         S_K2: begin
            if (stat.pn_zero) begin
               state_in = S_PICK;
            end else begin
               cmd.op   = nsdf_pkg::OP_DIVK2;
               state_in = S_K2_W;
            end
         end
         S_K2_W: begin
            if (stat.div_done) begin
               cmd.op   = nsdf_pkg::OP_KF2;
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if (stat.kf_gt_half) begin
               cmd.op   = nsdf_pkg::OP_SEMI;
               semi_in  = 1'b1;
               state_in = S_KN;
            end else if (stat.k2_zero) begin
               cmd.op   = nsdf_pkg::OP_RES_CUR;
               state_in = S_OUT;
            end else begin
               cmd.op   = nsdf_pkg::OP_HALF;
               semi_in  = 1'b0;
               state_in = S_KN;
            end
         end
         S_KN: begin
            cmd.op   = nsdf_pkg::OP_CN;
            state_in = S_KD;
         end
         S_KD: begin
            cmd.op   = nsdf_pkg::OP_CD;
            state_in = S_KEND;
         end
         S_KEND: begin
            if (semi_ff) begin
               cmd.op   = nsdf_pkg::OP_RES_CAND;
               state_in = S_OUT;
            end else if (stat.cand_over) begin
               cmd.op   = nsdf_pkg::OP_RES_CUR;
               state_in = S_OUT;
            end else begin
               sel_in   = 1'b0;
               step_in  = 3'd0;
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            cmd.op  = err_op;
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               if (sel_ff) begin
                  state_in = S_CMP;
               end else begin
                  sel_in = 1'b1;
               end
            end
         end
         S_CMP: begin
            cmd.op   = stat.new_wins ? nsdf_pkg::OP_RES_CAND : nsdf_pkg::OP_RES_CUR;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op   = nsdf_pkg::OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.op == nsdf_pkg::OP_OUT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      semi_ff <= semi_in;
      sel_ff  <= sel_in;
      step_ff <= step_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

/* rtl/core/nanosecond_duration_to_fraction.sv */
// top level: nanosecond duration to bounded fraction of seconds
// Converts a duration in nanoseconds into num/den seconds with both terms at most
// the csr limit (reset 65535); durations of limit+1 seconds or more, or a zero
// limit, give 1/0. One item is in work at a time and the time it takes is set by
// the data: factors of two are removed one at a time, factors of five are tried
// one at a time, the first quotient comes from the one-bit-per-cycle divider, and
// then come the continued-fraction steps, the bound quotients and the error
// comparison. An item out of range skips all of these. A finished result waits
// in the output register while the next beat is taken in.
`timescale 1ns / 1ps
`default_nettype none
module nanosecond_duration_to_fraction (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_duration_ns,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [31:0] rsp_frac_num,
   output logic      [31:0] rsp_frac_den,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);

   nsdf_pkg::cmd_type  cmd;
   nsdf_pkg::stat_type stat;

   nsdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   nsdf_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_duration_ns (req_duration_ns),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .stat            (stat),
      .rsp_frac_num    (rsp_frac_num),
      .rsp_frac_den    (rsp_frac_den)
   );

endmodule
`default_nettype wire

/* tb/nanosecond_duration_to_fraction_tb.sv */
// testbench for the nanosecond duration to bounded fraction block
`timescale 1ns / 1ps
module nanosecond_duration_to_fraction_tb;

   localparam int HANG_LIMIT = 20000;
   localparam int PHASES     = 10;
   localparam int PER_PHASE  = 140;

   typedef struct {
      logic [31:0] num;
      logic [31:0] den;
   } frac_type;

   typedef struct {
      logic [31:0] lim;
      logic [63:0] dur;
      bit          typed;
      logic [31:0] num;
      logic [31:0] den;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_duration_ns = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_frac_num;
   logic [31:0] rsp_frac_den;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   frac_type    pending_fracs[$];
   logic [31:0] cur_limit = nsdf_pkg::LIM_RESET;
   bit          idle_on = 1'b1;
   int          mismatches = 0;
   int          hang_cycles = 0;

   row_type directed[] = '{
      '{nsdf_pkg::LIM_RESET, 64'd0, 1, 32'd0, 32'd1},
      '{nsdf_pkg::LIM_RESET, 64'd1000000000, 1, 32'd1, 32'd1},
      '{nsdf_pkg::LIM_RESET, 64'd500000000, 1, 32'd1, 32'd2},
      '{nsdf_pkg::LIM_RESET, 64'd65536000000000, 1, 32'd1, 32'd0},
      '{nsdf_pkg::LIM_RESET, 64'd65535999999999, 0, 32'd0, 32'd0},
      '{nsdf_pkg::LIM_RESET, 64'hffffffffffffffff, 1, 32'd1, 32'd0},
      '{nsdf_pkg::LIM_RESET, 64'd333333333, 0, 32'd0, 32'd0},
      '{32'd0, 64'd0, 1, 32'd1, 32'd0},
      '{32'd0, 64'd1, 1, 32'd1, 32'd0},
      '{32'd1, 64'd0, 1, 32'd0, 32'd1},
      '{32'd1, 64'd1, 0, 32'd0, 32'd0},
      '{32'd1, 64'd1999999999, 0, 32'd0, 32'd0},
      '{32'd1, 64'd2000000000, 1, 32'd1, 32'd0},
      '{32'hffffffff, 64'd1, 1, 32'd1, 32'd1000000000},
      '{32'hffffffff, 64'd3, 1, 32'd3, 32'd1000000000},
      '{32'hffffffff, 64'd123456789, 0, 32'd0, 32'd0},
      '{32'hffffffff, 64'd4294967295999999999, 0, 32'd0, 32'd0},
      '{32'hffffffff, 64'd4294967296000000000, 1, 32'd1, 32'd0},
      '{32'hffffffff, 64'hffffffffffffffff, 1, 32'd1, 32'd0},
      '{32'd1000, 64'd3141592653, 0, 32'd0, 32'd0},
      '{32'd1000, 64'd1414213562, 0, 32'd0, 32'd0},
      '{32'd7, 64'd2718281828, 0, 32'd0, 32'd0},
      '{32'd100, 64'd1234567890123, 0, 32'd0, 32'd0}
   };

   nanosecond_duration_to_fraction u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_duration_ns(req_duration_ns),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_frac_num(rsp_frac_num),
      .rsp_frac_den(rsp_frac_den),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #10 clock = ~clock;

   // |d*q - p*qx| * m, kept to 128 bits
   function automatic logic [127:0] scaled_gap(input logic [63:0] d, input logic [63:0] qx,
                                               input logic [63:0] p, input logic [63:0] q,
                                               input logic [63:0] m);
      logic [127:0] a;
      logic [127:0] b;
      logic [127:0] gap;
      a = {64'd0, d} * {64'd0, q};
      b = {64'd0, p * qx};
      gap = (a >= b) ? a - b : b - a;
      return gap * {64'd0, m};
   endfunction

   function automatic frac_type best_fraction(input logic [63:0] dur, input logic [31:0] lim32);
      frac_type    r;
      logic [63:0] lim, d, qx, pn, qn, pp, qp, dv, rm, coef, t, cn, cd, half, kf, k2;
      lim = {32'd0, lim32};
      d = dur;
      qx = {32'd0, nsdf_pkg::NS_PER_SEC};
      if (lim == 0 || d >= qx * (lim + 64'd1)) begin
         r.num = 32'd1;
         r.den = 32'd0;
         return r;
      end
      while (((d | qx) & 64'd1) == 0) begin
         d = d >> 1;
         qx = qx >> 1;
      end
      while (d % 5 == 0 && qx % 5 == 0) begin
         d = d / 5;
         qx = qx / 5;
      end
      if (d <= lim && qx <= lim) begin
         r.num = d[31:0];
         r.den = qx[31:0];
         return r;
      end
      pn = d / qx; qn = 1; pp = 1; qp = 0;
      dv = qx; rm = d % qx;
      forever begin
         if (rm == 0) begin
            r.num = pn[31:0];
            r.den = qn[31:0];
            return r;
         end
         coef = dv / rm;
         t = dv % rm;
         dv = rm;
         rm = t;
         cn = pn * coef + pp;
         cd = qn * coef + qp;
         if (cn > lim || cd > lim) break;
         pp = pn; pn = cn;
         qp = qn; qn = cd;
      end
      kf = (lim - qp) / qn;
      if (pn != 0 && (lim - pp) / pn < kf) kf = (lim - pp) / pn;
      half = coef / 2 + 1;
      if (kf >= half) begin
         cn = pn * kf + pp;
         cd = qn * kf + qp;
         r.num = cn[31:0];
         r.den = cd[31:0];
         return r;
      end
      k2 = half - 1;
      if (k2 != 0) begin
         cn = pn * k2 + pp;
         cd = qn * k2 + qp;
         if (cn <= lim && cd <= lim &&
             scaled_gap(d, qx, cn, cd, qn) <= scaled_gap(d, qx, pn, qn, cd)) begin
            r.num = cn[31:0];
            r.den = cd[31:0];
            return r;
         end
      end
      r.num = pn[31:0];
      r.den = qn[31:0];
      return r;
   endfunction

   task automatic wait_drained();
      while (pending_fracs.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_limit(input logic [31:0] value);
      req_valid <= 1'b0;
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_limit = value;
   endtask

   task automatic send_beat(input logic [63:0] dur, input bit typed,
                            input logic [31:0] num, input logic [31:0] den);
      frac_type f;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_duration_ns <= dur;
      do @(posedge clock); while (!req_ready);
      f = best_fraction(dur, cur_limit);
      if (typed) begin
         f.num = num;
         f.den = den;
      end
      pending_fracs.push_back(f);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_limit(input int phase);
      case (phase % 8)
         0: return 32'hffffffff;
         1: return 32'd1;
         2: return 32'd0;
         3: return $urandom_range(2, 300);
         4: return nsdf_pkg::LIM_RESET;
         5: return $urandom_range(1000, 2000000);
         6: return $urandom;
         default: return $urandom_range(1, 20);
      endcase
   endfunction

   function automatic logic [63:0] pick_duration(input logic [31:0] lim);
      logic [63:0] bound;
      logic [63:0] pw;
      bound = {32'd0, nsdf_pkg::NS_PER_SEC} * ({32'd0, lim} + 64'd1);
      case ($urandom_range(0, 7))
         0: return {$urandom, $urandom};
         1: return $urandom_range(0, 2000000000);
         2: return bound - $urandom_range(0, 3);
         3: return bound + $urandom_range(0, 3);
         4: begin
            pw = 1;
            repeat ($urandom_range(0, 9)) pw = pw * 10;
            return ({32'd0, $urandom} * pw) % bound;
         end
         default: return {$urandom, $urandom} % bound;
      endcase
   endfunction

   always @(posedge clock) begin
      frac_type f;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) hang_cycles <= 0;
      else hang_cycles <= hang_cycles + 1;
      if (hang_cycles >= HANG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_fracs.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
               $display("unexpected beat %0d/%0d", rsp_frac_num, rsp_frac_den);
         end else begin
            f = pending_fracs.pop_front();
            if (f.num !== rsp_frac_num || f.den !== rsp_frac_den) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: expected %0d/%0d got %0d/%0d",
                           f.num, f.den, rsp_frac_num, rsp_frac_den);
            end
         end
      end
   end

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      forever begin
         if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
      end
   end

   initial begin
      repeat (13) @(negedge clock);
      foreach (directed[i]) begin
         if (directed[i].lim != cur_limit) write_limit(directed[i].lim);
         send_beat(directed[i].dur, directed[i].typed, directed[i].num, directed[i].den);
      end
      for (int p = 0; p < PHASES; p++) begin
         write_limit(pick_limit(p));
         if (p == PHASES - 1) idle_on = 1'b0;
         for (int n = 0; n < PER_PHASE; n++)
            send_beat(pick_duration(cur_limit), 1'b0, 32'd0, 32'd0);
      end
      req_valid <= 1'b0;
      wait_drained();
      repeat (50) @(posedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
